FILE: src/multi_list_splice_engine_core_macros.svh
// Assertion macros for the multi-list splice engine checker.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef MULTI_LIST_SPLICE_ENGINE_CORE_MACROS_SVH
`define MULTI_LIST_SPLICE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MLSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlse assertion failed");

// Next-cycle implication, disabled in reset.
`define MLSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlse assertion failed");

`endif

FILE: src/mlse_pkg.sv
// Shared constants, codes and types for the multi-list splice engine.
// Used by mlse_ctrl, mlse_dp, the top level and the checker.
package mlse_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int MAX_LISTS = 128;
    localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);
    localparam int LIST_W    = $clog2(MAX_LISTS + 1);
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_F2B   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_B2F   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPB   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SPA   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QLIST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QNEXT = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LIST = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ITEM = 2'd3;

    // configuration register indexes and reset values
    localparam logic CFG_NUM_BOOKS = 1'b0;
    localparam logic CFG_NUM_LISTS = 1'b1;
    localparam logic [ITEM_W-1:0] BOOKS_RST = ITEM_W'(1024);
    localparam logic [LIST_W-1:0] LISTS_RST = LIST_W'(100);

    typedef struct packed {
        logic [ITEM_W-1:0] head;
        logic [ITEM_W-1:0] tail;
        logic [ITEM_W-1:0] count;
    } row_t;

    // controller to datapath
    typedef struct packed {
        logic              cap_in;
        logic              row_rd_dst;
        logic              lat_src;
        logic              lat_dst;
        logic              lat_link;
        logic              wr1;
        logic              wr2;
        logic              init_start;
        logic              init_step;
        logic              load_out;
        logic [STAT_W-1:0] res_status;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad_src;
        logic             bad_dst;
        logic             bad_item;
        logic             src_empty;
        logic             same_list;
        logic             init_last;
    } sts_t;

endpackage

FILE: src/mlse_ctrl.sv
// Sequencing state machine of the multi-list splice engine.
// Depends on mlse_pkg; drives mlse_dp through ctl_t, reads sts_t.
module mlse_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output logic          res_valid,
    input  logic          res_ready,
    input  mlse_pkg::sts_t sts,
    output mlse_pkg::ctl_t ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD_S   = 4'd2;
    localparam logic [3:0] S_RD_D   = 4'd3;
    localparam logic [3:0] S_RD_L   = 4'd4;
    localparam logic [3:0] S_W1     = 4'd5;
    localparam logic [3:0] S_W2     = 4'd6;
    localparam logic [3:0] S_Q5     = 4'd7;
    localparam logic [3:0] S_Q6     = 4'd8;
    localparam logic [3:0] S_INIT   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic [mlse_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic                        res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.cap_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                stat_next = mlse_pkg::ST_OK;
                case (sts.cmd)
                    mlse_pkg::CMD_INIT:
                    begin
                        ctl.init_start = 1'b1;
                        state_next     = S_INIT;
                    end
                    mlse_pkg::CMD_F2B, mlse_pkg::CMD_B2F,
                    mlse_pkg::CMD_SPB, mlse_pkg::CMD_SPA:
                    begin
                        if (sts.bad_src || sts.bad_dst)
                        begin
                            stat_next  = mlse_pkg::ST_BAD_LIST;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_RD_S;
                        end
                    end
                    mlse_pkg::CMD_QLIST:
                    begin
                        if (sts.bad_src)
                        begin
                            stat_next  = mlse_pkg::ST_BAD_LIST;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_Q5;
                        end
                    end
                    mlse_pkg::CMD_QNEXT:
                    begin
                        if (sts.bad_item)
                        begin
                            stat_next  = mlse_pkg::ST_BAD_ITEM;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_Q6;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RD_S:
            begin
                ctl.lat_src    = 1'b1;
                ctl.row_rd_dst = 1'b1;
                state_next     = S_RD_D;
            end
            S_RD_D:
            begin
                ctl.lat_dst = 1'b1;
                if (sts.src_empty)
                begin
                    stat_next  = mlse_pkg::ST_EMPTY;
                    state_next = S_FIN;
                end
                else if (sts.cmd == mlse_pkg::CMD_F2B || sts.cmd == mlse_pkg::CMD_B2F)
                begin
                    state_next = S_RD_L;
                end
                else if (sts.same_list)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_W1;
                end
            end
            S_RD_L:
            begin
                ctl.lat_link = 1'b1;
                state_next   = S_W1;
            end
            S_W1:
            begin
                ctl.wr1    = 1'b1;
                state_next = S_W2;
            end
            S_W2:
            begin
                ctl.wr2    = 1'b1;
                state_next = S_FIN;
            end
            S_Q5:
            begin
                ctl.lat_src = 1'b1;
                state_next  = S_FIN;
            end
            S_Q6:
            begin
                ctl.lat_link = 1'b1;
                state_next   = S_FIN;
            end
            S_INIT:
            begin
                ctl.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ctl.res_status = stat_reg;
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_reg      <= mlse_pkg::ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

FILE: src/mlse_dp.sv
// Datapath of the multi-list splice engine: link memories, list table,
// configuration and result registers. Depends on mlse_pkg.
module mlse_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mlse_pkg::CFG_W-1:0]    cfg_data,
    input  logic [mlse_pkg::CMD_W-1:0]    cmd,
    input  logic [mlse_pkg::LIST_W-1:0]   src_list,
    input  logic [mlse_pkg::LIST_W-1:0]   dst_list,
    input  logic [mlse_pkg::ITEM_W-1:0]   item,
    input  mlse_pkg::ctl_t                ctl,
    output mlse_pkg::sts_t                sts,
    output logic [mlse_pkg::STAT_W-1:0]   status,
    output logic [mlse_pkg::ITEM_W-1:0]   count,
    output logic [mlse_pkg::ITEM_W-1:0]   found_item
);

    localparam int IW = mlse_pkg::ITEM_W;
    localparam int LW = mlse_pkg::LIST_W;

    // valid pattern after init: only list one holds items
    localparam logic [mlse_pkg::MAX_LISTS:0] ROW1_ONLY =
        {{(mlse_pkg::MAX_LISTS-1){1'b0}}, 2'b10};

    logic [IW-1:0] books_reg;
    logic [LW-1:0] lists_reg;
    logic [IW-1:0] eff_books;
    logic [LW-1:0] eff_lists;

    logic [mlse_pkg::CMD_W-1:0] cmd_reg;
    logic [LW-1:0]              src_reg, dst_reg;
    logic [IW-1:0]              item_reg;

    // list table and link memories
    mlse_pkg::row_t row_mem [0:mlse_pkg::MAX_LISTS];
    logic [mlse_pkg::MAX_LISTS:0] row_vld_reg;
    mlse_pkg::row_t row_q;
    logic           vld_q;
    mlse_pkg::row_t row_rd;
    logic [LW-1:0]  row_ra;
    logic           row_we;
    logic [LW-1:0]  row_wa;
    mlse_pkg::row_t row_wd;

    logic [IW-1:0] next_mem [0:mlse_pkg::MAX_ITEMS];
    logic [IW-1:0] prev_mem [0:mlse_pkg::MAX_ITEMS];
    logic [IW-1:0] next_q, prev_q;
    logic [IW-1:0] link_ra;
    logic          next_we, prev_we;
    logic [IW-1:0] next_wa, next_wd, prev_wa, prev_wd;

    mlse_pkg::row_t srow_reg, drow_reg;
    logic [IW-1:0]  lk_reg;
    logic [IW-1:0]  ctr_reg;

    mlse_pkg::row_t s_after, dr, d_after;
    logic [IW-1:0]  x;

    logic [mlse_pkg::STAT_W-1:0] status_reg;
    logic [IW-1:0]               count_reg, found_reg;

    // configuration, clamped into the legal ranges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            books_reg <= mlse_pkg::BOOKS_RST;
            lists_reg <= mlse_pkg::LISTS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mlse_pkg::CFG_NUM_BOOKS)
            begin
                books_reg <= cfg_data[IW-1:0];
            end
            else
            begin
                lists_reg <= cfg_data[LW-1:0];
            end
        end
    end

    always_comb
    begin
        if (books_reg == '0)
        begin
            eff_books = IW'(1);
        end
        else if (books_reg > IW'(mlse_pkg::MAX_ITEMS))
        begin
            eff_books = IW'(mlse_pkg::MAX_ITEMS);
        end
        else
        begin
            eff_books = books_reg;
        end
        if (lists_reg == '0)
        begin
            eff_lists = LW'(1);
        end
        else if (lists_reg > LW'(mlse_pkg::MAX_LISTS))
        begin
            eff_lists = LW'(mlse_pkg::MAX_LISTS);
        end
        else
        begin
            eff_lists = lists_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
        begin
            cmd_reg  <= cmd;
            src_reg  <= src_list;
            dst_reg  <= dst_list;
            item_reg <= item;
        end
        if (ctl.lat_src)
        begin
            srow_reg <= row_rd;
        end
        if (ctl.lat_dst)
        begin
            drow_reg <= row_rd;
        end
        if (ctl.lat_link)
        begin
            lk_reg <= (cmd_reg == mlse_pkg::CMD_B2F) ? prev_q : next_q;
        end
    end

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.bad_src   = (src_reg == '0) || (src_reg > eff_lists);
        sts.bad_dst   = (dst_reg == '0) || (dst_reg > eff_lists);
        sts.bad_item  = (item_reg == '0) || (item_reg > eff_books);
        sts.src_empty = (srow_reg.head == '0);
        sts.same_list = (src_reg == dst_reg);
        sts.init_last = (ctr_reg == IW'(mlse_pkg::MAX_ITEMS));
    end

    // list table: registered read, never-written rows read as empty
    assign row_ra = ctl.row_rd_dst ? dst_reg : src_reg;
    assign row_rd = vld_q ? row_q : '0;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_q <= row_mem[row_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            vld_q       <= 1'b0;
        end
        else
        begin
            vld_q <= row_vld_reg[row_ra];
            if (ctl.init_start)
            begin
                row_vld_reg <= ROW1_ONLY;
            end
            else if (row_we)
            begin
                row_vld_reg[row_wa] <= 1'b1;
            end
        end
    end

    // link memories
    always_comb
    begin
        if (cmd_reg == mlse_pkg::CMD_QNEXT)
        begin
            link_ra = item_reg;
        end
        else if (cmd_reg == mlse_pkg::CMD_B2F)
        begin
            link_ra = srow_reg.tail;
        end
        else
        begin
            link_ra = srow_reg.head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        next_q <= next_mem[link_ra];
        prev_q <= prev_mem[link_ra];
    end

    // init walk counter over every link entry
    always_ff @(posedge clk)
    begin
        if (ctl.init_start)
        begin
            ctr_reg <= '0;
        end
        else if (ctl.init_step)
        begin
            ctr_reg <= ctr_reg + IW'(1);
        end
    end

    // source row after the take, destination row after the put
    always_comb
    begin
        x = (cmd_reg == mlse_pkg::CMD_B2F) ? srow_reg.tail : srow_reg.head;
        case (cmd_reg)
            mlse_pkg::CMD_F2B:
            begin
                s_after.head  = lk_reg;
                s_after.tail  = (lk_reg == '0) ? '0 : srow_reg.tail;
                s_after.count = srow_reg.count - IW'(1);
            end
            mlse_pkg::CMD_B2F:
            begin
                s_after.head  = (lk_reg == '0) ? '0 : srow_reg.head;
                s_after.tail  = lk_reg;
                s_after.count = srow_reg.count - IW'(1);
            end
            default:
            begin
                s_after = '0;
            end
        endcase
        dr = sts.same_list ? s_after : drow_reg;
        d_after = dr;
        case (cmd_reg)
            mlse_pkg::CMD_F2B:
            begin
                d_after.count = dr.count + IW'(1);
                d_after.tail  = x;
                if (dr.tail == '0)
                begin
                    d_after.head = x;
                end
            end
            mlse_pkg::CMD_B2F:
            begin
                d_after.count = dr.count + IW'(1);
                d_after.head  = x;
                if (dr.head == '0)
                begin
                    d_after.tail = x;
                end
            end
            mlse_pkg::CMD_SPB:
            begin
                d_after.count = dr.count + srow_reg.count;
                d_after.head  = srow_reg.head;
                if (dr.head == '0)
                begin
                    d_after.tail = srow_reg.tail;
                end
            end
            default:
            begin
                d_after.count = dr.count + srow_reg.count;
                d_after.tail  = srow_reg.tail;
                if (dr.head == '0)
                begin
                    d_after.head = srow_reg.head;
                end
            end
        endcase
    end

    // write ports
    always_comb
    begin
        row_we  = 1'b0;
        row_wa  = src_reg;
        row_wd  = s_after;
        next_we = 1'b0;
        next_wa = x;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = x;
        prev_wd = '0;
        if (ctl.init_start)
        begin
            row_we       = 1'b1;
            row_wa       = LW'(1);
            row_wd.head  = IW'(1);
            row_wd.tail  = eff_books;
            row_wd.count = eff_books;
        end
        else if (ctl.init_step)
        begin
            next_we = 1'b1;
            next_wa = ctr_reg;
            next_wd = (ctr_reg != '0 && ctr_reg < eff_books) ? ctr_reg + IW'(1) : '0;
            prev_we = 1'b1;
            prev_wa = ctr_reg;
            prev_wd = (ctr_reg > IW'(1) && ctr_reg <= eff_books) ? ctr_reg - IW'(1) : '0;
        end
        else if (ctl.wr1)
        begin
            row_we = 1'b1;
            if (cmd_reg == mlse_pkg::CMD_F2B)
            begin
                next_we = 1'b1;
                prev_we = (lk_reg != '0);
                prev_wa = lk_reg;
            end
            else if (cmd_reg == mlse_pkg::CMD_B2F)
            begin
                prev_we = 1'b1;
                next_we = (lk_reg != '0);
                next_wa = lk_reg;
            end
        end
        else if (ctl.wr2)
        begin
            row_we = 1'b1;
            row_wa = dst_reg;
            row_wd = d_after;
            case (cmd_reg)
                mlse_pkg::CMD_F2B:
                begin
                    next_we = (dr.tail != '0);
                    next_wa = dr.tail;
                    next_wd = x;
                    prev_we = (dr.tail != '0);
                    prev_wd = dr.tail;
                end
                mlse_pkg::CMD_B2F:
                begin
                    next_we = (dr.head != '0);
                    next_wd = dr.head;
                    prev_we = (dr.head != '0);
                    prev_wa = dr.head;
                    prev_wd = x;
                end
                mlse_pkg::CMD_SPB:
                begin
                    next_we = (dr.head != '0);
                    next_wa = srow_reg.tail;
                    next_wd = dr.head;
                    prev_we = (dr.head != '0);
                    prev_wa = dr.head;
                    prev_wd = srow_reg.tail;
                end
                default:
                begin
                    next_we = (dr.head != '0);
                    next_wa = dr.tail;
                    next_wd = srow_reg.head;
                    prev_we = (dr.head != '0);
                    prev_wa = srow_reg.head;
                    prev_wd = dr.tail;
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            status_reg <= ctl.res_status;
            if (ctl.res_status == mlse_pkg::ST_OK && cmd_reg == mlse_pkg::CMD_QLIST)
            begin
                count_reg <= srow_reg.count;
                found_reg <= srow_reg.head;
            end
            else if (ctl.res_status == mlse_pkg::ST_OK && cmd_reg == mlse_pkg::CMD_QNEXT)
            begin
                count_reg <= '0;
                found_reg <= lk_reg;
            end
            else
            begin
                count_reg <= '0;
                found_reg <= '0;
            end
        end
    end

    assign status     = status_reg;
    assign count      = count_reg;
    assign found_item = found_reg;

endmodule

FILE: src/multi_list_splice_engine_core.sv
// Top level of the multi-list splice engine: controller plus datapath.
// Depends on mlse_pkg, mlse_ctrl and mlse_dp.
//
// Keeps items 1..1024 threaded into up to 128 doubly linked lists, with
// next/prev link memories and a head/tail/count table per list. One command
// word is taken at a time on the cmd channel and gives exactly one result
// word on the res channel. Init walks all 1025 link entries, writing one
// per cycle. The single-item moves are sequenced by the one-read, one-write
// list table and link memories: source row, destination row and link are
// read in turn, then the source and destination sides are written in turn.
// A result that is not taken holds the engine in its final step; the next
// command word may still be taken while a result waits. Lists are empty
// after reset (per-row valid bits); links are undefined until the first
// init, so a next query before init returns junk. Configuration (cfg_index
// 0 num_books, 1 num_lists) must be written only while the engine is idle;
// the block does not enforce this. Values out of range are clamped.
module multi_list_splice_engine_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [mlse_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [mlse_pkg::CMD_W-1:0]          cmd,
    input  logic [mlse_pkg::LIST_W-1:0]         src_list,
    input  logic [mlse_pkg::LIST_W-1:0]         dst_list,
    input  logic [mlse_pkg::ITEM_W-1:0]         item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [mlse_pkg::STAT_W-1:0]         status,
    output logic [mlse_pkg::ITEM_W-1:0]         count,
    output logic [mlse_pkg::ITEM_W-1:0]         found_item
);

    mlse_pkg::ctl_t ctl;   // sequencing commands
    mlse_pkg::sts_t sts;   // decode and condition flags

    mlse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    mlse_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .src_list   (src_list),
        .dst_list   (dst_list),
        .item       (item),
        .ctl        (ctl),
        .sts        (sts),
        .status     (status),
        .count      (count),
        .found_item (found_item)
    );

endmodule

FILE: src/mlse_checker.sv
// Port-level checker for the multi-list splice engine, bound to the top.
// Depends on mlse_pkg and multi_list_splice_engine_core_macros.svh.
`include "multi_list_splice_engine_core_macros.svh"

module mlse_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [mlse_pkg::STAT_W-1:0] status,
    input logic [mlse_pkg::ITEM_W-1:0] count,
    input logic [mlse_pkg::ITEM_W-1:0] found_item
);

    // stalled result word holds
    `MLSE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(count) && $stable(found_item))

    // error words carry no count or item
    `MLSE_ASSERT_NOW(a_err_clean, res_valid && status != mlse_pkg::ST_OK, count == '0 && found_item == '0)

    // one word in flight: no second take straight after a take
    `MLSE_ASSERT_NXT(a_one_busy, cmd_valid && cmd_ready, !cmd_ready)

    // a count never exceeds the pool
    `MLSE_ASSERT_NOW(a_cnt_range, res_valid, count <= mlse_pkg::ITEM_W'(mlse_pkg::MAX_ITEMS))

endmodule

bind multi_list_splice_engine_core mlse_checker u_mlse_checker (.*);
